[sv/wpd_pkg.sv]
// Package: shared types, codes and constants for the WAV PCM stream decoder.
package wpd_pkg;

  localparam int unsigned MaxChannelsDefault = 8;

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_CHUNK_HEAD = 3'd1,
    PH_SKIP       = 3'd2,
    PH_FORMAT     = 3'd3,
    PH_PAD        = 3'd4,
    PH_DATA       = 3'd5,
    PH_DONE       = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_SAMPLE      = 3'd0,
    KIND_FINISHED    = 3'd1,
    KIND_NOT_WAV     = 3'd2,
    KIND_UNSUPPORTED = 3'd3,
    KIND_NO_RATE     = 3'd4,
    KIND_NO_DATA     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    SQ_IDLE   = 2'd0,
    SQ_DIVIDE = 2'd1,
    SQ_EMIT   = 2'd2
  } seq_t;

  localparam logic [31:0] TagRiff = 32'h46464952;
  localparam logic [31:0] TagWave = 32'h45564157;
  localparam logic [31:0] TagFmt  = 32'h20746D66;
  localparam logic [31:0] TagData = 32'h61746164;
  localparam logic [15:0] FormatPcm = 16'd1;
  localparam logic [15:0] FormatFloat = 16'd3;
  localparam logic [15:0] FormatExtensible = 16'hFFFE;

  localparam int SumWidth = 40;

  // Convert an IEEE single to Q1.31, truncating toward zero, saturating.
  function automatic logic signed [32:0] float_to_q31(input logic [31:0] w);
    logic [7:0] e;
    logic [23:0] m;
    logic [31:0] mag;
    logic [32:0] res;
    e = w[30:23];
    m = {1'b1, w[22:0]};
    mag = '0;
    res = '0;
    if (e == 8'd255 && w[22:0] != 23'd0) begin
      res = '0;
    end else if (e >= 8'd127) begin
      res = w[31] ? 33'h1_8000_0000 : 33'h0_7FFF_FFFF;
    end else if (e == 8'd0) begin
      res = '0;
    end else begin
      if (e >= 8'd119) begin
        mag = {8'd0, m} << (e - 8'd119);
      end else if ((8'd119 - e) >= 8'd24) begin
        mag = '0;
      end else begin
        mag = {8'd0, m >> (8'd119 - e)};
      end
      res = w[31] ? (33'd0 - {1'b0, mag}) : {1'b0, mag};
    end
    return res;
  endfunction

endpackage

[sv/wpd_divider.sv]
// Module: restoring divider, one quotient bit a cycle, signed by magnitude.
module wpd_divider import wpd_pkg::*; #(
  parameter int ChanWidth = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SumWidth-1:0] dividend,
  input  logic [ChanWidth-1:0]       divisor,
  output logic                       done,
  output logic signed [31:0]         quotient
);

  localparam int CntWidth = $clog2(SumWidth + 1);

  logic [SumWidth-1:0]  quo;
  logic [ChanWidth-1:0] rem;
  logic [ChanWidth-1:0] dvs;
  logic                 neg;
  logic [CntWidth-1:0]  cnt;
  logic                 busy;
  logic [ChanWidth:0]   trial;
  logic [SumWidth-1:0]  neg_quo;

  assign trial = {rem, quo[SumWidth-1]};
  assign neg_quo = neg ? (~quo + 1'b1) : quo;

  // While busy, one dividend bit shifts in and a subtract is tried each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntWidth'(SumWidth);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SumWidth-1];
      quo <= dividend[SumWidth-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= ChanWidth'(trial - {1'b0, dvs});
        quo <= {quo[SumWidth-2:0], 1'b1};
      end else begin
        rem <= trial[ChanWidth-1:0];
        quo <= {quo[SumWidth-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg_quo[31:0];

  // Done is a single pulse after a start.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("divider done held");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy) else $error("divider not busy after start");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without work");

endmodule

[sv/wav_pcm_stream_decoder.sv]
// Module: top level of the byte-serial RIFF WAV PCM decoder.
// The decoder takes one file byte per beat and gives up to two result beats per byte.
// A byte that causes no result leaves the decoder ready again, and one that causes a
// result holds it until the result is taken; the byte that closes a frame first runs
// the bit-serial divider (40 steps), which divides the channel sum by the channel
// count. The decoder is not ready while a byte is in work or a result waits, and after
// the byte marked end of file its parser state returns to reset.
module wav_pcm_stream_decoder import wpd_pkg::*; #(
  parameter int MAX_CHANNELS = MaxChannelsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] mono_sample, [63:32] sample_rate
  output logic [2:0]  m_tuser,   // [2:0] kind
  output logic        m_tlast    // last
);

  localparam int ChanWidth = $clog2(MAX_CHANNELS + 1);

  seq_t   seq, seq_next;
  phase_t phase;
  logic [3:0]  hdr_idx;
  logic [31:0] tag_shift, chunk_length, chunk_offset, rate_value, sample_asm;
  logic [15:0] format_code, channel_total, bits_per_sample;
  logic [2:0]  byte_cnt;
  logic [ChanWidth-1:0] chan_idx;
  logic signed [SumWidth-1:0] mix_sum;

  // Pending results: a sample from the divider, then an optional final kind.
  logic        samp_pend;
  logic        fin_pend;
  kind_t       fin_kind;
  logic [31:0] fin_rate;

  // Byte step decisions.
  logic        fin_pend_n;
  kind_t       fin_kind_n;
  logic [31:0] fin_rate_n;

  logic        div_start, div_done;
  logic signed [SumWidth-1:0] div_num;
  logic signed [31:0] div_q;

  logic accept;
  assign accept = s_tvalid && s_tready;
  assign s_tready = (seq == SQ_IDLE);

  wpd_divider #(.ChanWidth(ChanWidth)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(channel_total[ChanWidth-1:0]), .done(div_done), .quotient(div_q)
  );

  // Combinational view of the byte step.
  logic [31:0] shifted_tag, shifted_len, shifted_asm, nxt_off, cur_rate;
  logic [2:0]  width_bytes;
  logic        supported, frame_done, sample_done;
  logic signed [32:0] conv;
  logic signed [SumWidth-1:0] sum_add;

  always_comb begin
    shifted_tag = {s_tdata, tag_shift[31:8]};
    shifted_len = {s_tdata, chunk_length[31:8]};
    shifted_asm = {s_tdata, sample_asm[31:8]};
    nxt_off = chunk_offset + 32'd1;
    width_bytes = bits_per_sample[5:3];
    sample_done = ({1'b0, byte_cnt} + 4'd1) >= {1'b0, width_bytes};
    conv = (format_code == FormatFloat) ? float_to_q31(shifted_asm)
                                        : {shifted_asm[31], shifted_asm};
    sum_add = mix_sum + SumWidth'(conv);
    frame_done = sample_done && ({{(16-ChanWidth){1'b0}}, chan_idx} + 16'd1 >= channel_total);
    supported = channel_total != 16'd0 && channel_total <= 16'(MAX_CHANNELS) &&
      ((format_code == FormatPcm && (bits_per_sample == 16'd16 ||
        bits_per_sample == 16'd24 || bits_per_sample == 16'd32)) ||
       (format_code == FormatFloat && bits_per_sample == 16'd32));
    cur_rate = rate_value;
  end

  assign div_num = sum_add;

  // Sequencer next state.
  always_comb begin
    seq_next = seq;
    unique case (seq)
      SQ_IDLE: begin
        if (accept && div_start) seq_next = SQ_DIVIDE;
        else if (accept && fin_pend_n) seq_next = SQ_EMIT;
      end
      SQ_DIVIDE: if (div_done) seq_next = SQ_EMIT;
      SQ_EMIT: if (m_tvalid && m_tready && m_tlast) seq_next = SQ_IDLE;
      default: seq_next = SQ_IDLE;
    endcase
  end

  // Byte step decisions (outputs of the idle state).
  always_comb begin
    fin_pend_n = 1'b0;
    fin_kind_n = KIND_NO_DATA;
    fin_rate_n = '0;
    div_start = 1'b0;
    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          if (((hdr_idx < 4'd4) && s_tdata != TagRiff[8*hdr_idx[1:0] +: 8]) ||
              ((hdr_idx >= 4'd8) && s_tdata != TagWave[8*hdr_idx[1:0] +: 8])) begin
            fin_pend_n = 1'b1;
            fin_kind_n = KIND_NOT_WAV;
          end
        end
        PH_CHUNK_HEAD: begin
          if (chunk_offset[2:0] == 3'd7 && tag_shift == TagData) begin
            if (!supported) begin
              fin_pend_n = 1'b1;
              fin_kind_n = KIND_UNSUPPORTED;
            end else if (rate_value == 32'd0) begin
              fin_pend_n = 1'b1;
              fin_kind_n = KIND_NO_RATE;
            end else if (shifted_len == 32'd0) begin
              fin_pend_n = 1'b1;
              fin_kind_n = KIND_FINISHED;
              fin_rate_n = cur_rate;
            end
          end
        end
        PH_DATA: begin
          div_start = frame_done;
          if (nxt_off == chunk_length) begin
            fin_pend_n = 1'b1;
            fin_kind_n = KIND_FINISHED;
            fin_rate_n = cur_rate;
          end
        end
        default: ;
      endcase
      // A clean twelfth header byte already moves on to the chunk walk.
      if (s_tlast && !fin_pend_n && phase != PH_DONE) begin
        fin_pend_n = 1'b1;
        fin_kind_n = (phase == PH_HEADER && hdr_idx != 4'd11) ? KIND_NOT_WAV : KIND_NO_DATA;
      end
    end
  end

  // Result beat drive.
  always_comb begin
    m_tvalid = (seq == SQ_EMIT) && (samp_pend || fin_pend);
    m_tuser = samp_pend ? KIND_SAMPLE : fin_kind;
    m_tdata = samp_pend ? {32'd0, div_q} : {fin_rate, 32'd0};
    m_tlast = samp_pend ? !fin_pend : 1'b1;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SQ_IDLE;
      samp_pend <= 1'b0;
      fin_pend <= 1'b0;
    end else begin
      seq <= seq_next;
      if (accept) begin
        samp_pend <= div_start;
        fin_pend <= fin_pend_n;
      end else if (m_tvalid && m_tready) begin
        if (samp_pend) samp_pend <= 1'b0;
        else fin_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fin_kind <= fin_kind_n;
      fin_rate <= fin_rate_n;
    end
  end

  // Parser state: advance on each accepted byte, clear at end of file.
  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      phase <= PH_HEADER;
      hdr_idx <= '0;
      tag_shift <= '0;
      chunk_length <= '0;
      chunk_offset <= '0;
      format_code <= '0;
      channel_total <= '0;
      rate_value <= '0;
      bits_per_sample <= '0;
      sample_asm <= '0;
      byte_cnt <= '0;
      chan_idx <= '0;
      mix_sum <= '0;
    end else if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          if (fin_pend_n) phase <= PH_DONE;
          else if (hdr_idx == 4'd11) begin
            phase <= PH_CHUNK_HEAD;
            chunk_offset <= '0;
          end
          hdr_idx <= hdr_idx + 4'd1;
        end
        PH_CHUNK_HEAD: begin
          if (chunk_offset[2]) chunk_length <= shifted_len;
          else tag_shift <= shifted_tag;
          chunk_offset <= chunk_offset + 32'd1;
          if (chunk_offset[2:0] == 3'd7) begin
            chunk_offset <= '0;
            if (tag_shift == TagData) begin
              if (fin_pend_n) phase <= PH_DONE;
              else phase <= PH_DATA;
              mix_sum <= '0;
              chan_idx <= '0;
              sample_asm <= '0;
              byte_cnt <= '0;
            end else if (tag_shift == TagFmt && shifted_len >= 32'd16) begin
              tag_shift <= '0;
              phase <= PH_FORMAT;
            end else begin
              phase <= (shifted_len == 32'd0) ? PH_CHUNK_HEAD : PH_SKIP;
            end
          end
        end
        PH_SKIP, PH_FORMAT: begin
          if (phase == PH_FORMAT) begin
            tag_shift <= shifted_tag;
            if (chunk_offset == 32'd1) format_code <= shifted_tag[31:16];
            else if (chunk_offset == 32'd3) channel_total <= shifted_tag[31:16];
            else if (chunk_offset == 32'd7) rate_value <= shifted_tag;
            else if (chunk_offset == 32'd15) bits_per_sample <= shifted_tag[31:16];
            else if (chunk_offset == 32'd25 && format_code == FormatExtensible &&
                     chunk_length >= 32'd26) format_code <= shifted_tag[31:16];
          end
          chunk_offset <= nxt_off;
          if (nxt_off == chunk_length) begin
            chunk_offset <= '0;
            phase <= chunk_length[0] ? PH_PAD : PH_CHUNK_HEAD;
          end
        end
        PH_PAD: begin
          chunk_offset <= '0;
          phase <= PH_CHUNK_HEAD;
        end
        PH_DATA: begin
          chunk_offset <= nxt_off;
          if (sample_done) begin
            sample_asm <= '0;
            byte_cnt <= '0;
            if (frame_done) begin
              mix_sum <= '0;
              chan_idx <= '0;
            end else begin
              mix_sum <= sum_add;
              chan_idx <= chan_idx + 1'b1;
            end
          end else begin
            sample_asm <= shifted_asm;
            byte_cnt <= byte_cnt + 3'd1;
          end
          if (nxt_off == chunk_length) phase <= PH_DONE;
        end
        default: ;
      endcase
    end
  end

  // A sample beat only shows after the divider has finished.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (seq != SQ_IDLE) |-> !s_tready) else $error("byte taken while busy");
  a_emit_has_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (seq == SQ_EMIT)) else $error("result outside emit");
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (seq == SQ_IDLE)) else $error("divide started while busy");

endmodule
